[rtl/thdf_pkg.sv]
// ----------------------------------------------------------------------------
// thdf_pkg
// Shared types and constants for the tagged header deframer.
// ----------------------------------------------------------------------------
package thdf_pkg;

    // Header window geometry
    localparam int WinLen    = 20;
    localparam int FillW     = $clog2(WinLen + 1);
    localparam int MarkLen   = 4;
    localparam int LenOffset = 8;

    localparam logic [7:0] StartMark = 8'hFF;
    localparam logic [7:0] EndMark   = 8'hFE;

    // Input stage contents
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
        logic       abort;
    } stage_t;

    // One result transaction
    typedef struct packed {
        logic [7:0]  body_byte;
        logic        last_of_frame;
        logic        empty_frame;
        logic        aborted;
        logic [31:0] frame_length;
    } result_t;

endpackage

[rtl/thdf_in_reg.sv]
// ----------------------------------------------------------------------------
// thdf_in_reg
// Input register: captures one transaction and holds it until the deframe
// stage consumes it.
// ----------------------------------------------------------------------------
module thdf_in_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  logic             abort,
    input  logic             take,
    output thdf_pkg::stage_t stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       abort_reg;
    logic       load;

    // Free slot, or the held item leaves this cycle
    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= rx_byte;
            abort_reg <= abort;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.rx_byte = byte_reg;
    assign stage.abort   = abort_reg;

endmodule

[rtl/thdf_deframe.sv]
// ----------------------------------------------------------------------------
// thdf_deframe
// Header hunt, body pass-through and the result register.
// ----------------------------------------------------------------------------
module thdf_deframe
(
    input  logic              clk,
    input  logic              rst_n,
    input  thdf_pkg::stage_t  stage,
    output logic              take,
    output logic              out_valid,
    input  logic              out_ready,
    output thdf_pkg::result_t result
);

    localparam int WinLen = thdf_pkg::WinLen;
    localparam int FillW  = thdf_pkg::FillW;

    logic [7:0]       win_reg [WinLen];
    logic [7:0]       win_next [WinLen];
    logic [FillW-1:0] fill_reg;
    logic [FillW-1:0] fill_next;
    logic             in_body_reg;
    logic             in_body_next;
    logic [31:0]      len_reg;
    logic [31:0]      len_next;
    logic [31:0]      count_reg;
    logic [31:0]      count_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    thdf_pkg::result_t res_reg;
    thdf_pkg::result_t res_next;
    logic              has_result;

    logic        lock;
    logic        last;
    logic [31:0] hdr_len;

    // Stage moves when the result register is free or draining
    assign take = stage.valid && (!out_valid_reg || out_ready);

    // Window after shifting in the current byte
    always_comb
    begin
        for (int i = 0; i < WinLen - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WinLen - 1] = stage.rx_byte;
    end

    // Lock test on the shifted window
    always_comb
    begin
        lock = (fill_reg >= FillW'(WinLen - 1));
        for (int i = 0; i < thdf_pkg::MarkLen; i++)
        begin
            if (win_next[i] != thdf_pkg::StartMark)
            begin
                lock = 1'b0;
            end
            if (win_next[WinLen - thdf_pkg::MarkLen + i] != thdf_pkg::EndMark)
            begin
                lock = 1'b0;
            end
        end
    end

    // Little-endian length field
    assign hdr_len = {win_next[thdf_pkg::LenOffset + 3], win_next[thdf_pkg::LenOffset + 2],
                      win_next[thdf_pkg::LenOffset + 1], win_next[thdf_pkg::LenOffset]};

    assign last = ((count_reg + 32'd1) == len_reg);

    // Frame state and result
    always_comb
    begin
        fill_next    = fill_reg;
        in_body_next = in_body_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        has_result   = 1'b0;
        res_next     = '0;

        if (take)
        begin
            if (stage.abort)
            begin
                has_result            = 1'b1;
                res_next.aborted      = 1'b1;
                res_next.frame_length = in_body_reg ? len_reg : 32'd0;
                fill_next             = '0;
                in_body_next          = 1'b0;
                len_next              = '0;
                count_next            = '0;
            end
            else if (in_body_reg)
            begin
                has_result             = 1'b1;
                res_next.body_byte     = stage.rx_byte;
                res_next.last_of_frame = last;
                res_next.frame_length  = len_reg;
                count_next             = count_reg + 32'd1;
                if (last)
                begin
                    fill_next    = '0;
                    in_body_next = 1'b0;
                    count_next   = '0;
                end
            end
            else if (lock)
            begin
                len_next   = hdr_len;
                fill_next  = '0;
                count_next = '0;
                if (hdr_len == 32'd0)
                begin
                    has_result             = 1'b1;
                    res_next.last_of_frame = 1'b1;
                    res_next.empty_frame   = 1'b1;
                end
                else
                begin
                    in_body_next = 1'b1;
                end
            end
            else if (fill_reg < FillW'(WinLen))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // Result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = has_result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            in_body_reg   <= 1'b0;
            len_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            in_body_reg   <= in_body_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Window shifts only while hunting; the fill count guards stale bytes
    always_ff @(posedge clk)
    begin
        if (take && !stage.abort && !in_body_reg)
        begin
            for (int i = 0; i < WinLen; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
        if (take && has_result)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

[rtl/tagged_header_deframer.sv]
// ----------------------------------------------------------------------------
// tagged_header_deframer
// Hunts for a tagged 20-byte header in a byte stream, passes the body bytes it
// announces, flags the last one, and reports empty and aborted frames.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | in_valid / in_ready | rx_byte, abort
//  output   | out_valid/out_ready | body_byte, last_of_frame, empty_frame,
//           |                     | aborted, frame_length
//
// One byte per clock unless the output stalls. Path: input register, then
// the window compare and frame counter feeding the result register.
// Reset clears the hunt state, the counters and both valid flags.
// A stalled output holds the result; the input register keeps accepting
// while the held result is drained in the same cycle.
// ----------------------------------------------------------------------------
module tagged_header_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        abort,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  body_byte,
    output logic        last_of_frame,
    output logic        empty_frame,
    output logic        aborted,
    output logic [31:0] frame_length
);

    thdf_pkg::stage_t  stage;
    thdf_pkg::result_t result;
    logic              take;

    thdf_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .abort    (abort),
        .take     (take),
        .stage    (stage)
    );

    thdf_deframe u_deframe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign body_byte     = result.body_byte;
    assign last_of_frame = result.last_of_frame;
    assign empty_frame   = result.empty_frame;
    assign aborted       = result.aborted;
    assign frame_length  = result.frame_length;

endmodule
